>>> hdl/ipv4_l4_header_extractor_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the header extractor modules.
// Each macro expects signals named clk and rst_n in the using module.
// ----------------------------------------------------------------------------
`ifndef IPV4_L4_HEADER_EXTRACTOR_UNIT_DEFINES_SVH
`define IPV4_L4_HEADER_EXTRACTOR_UNIT_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define L4HX_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define L4HX_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/l4hx_pkg.sv
// ----------------------------------------------------------------------------
// l4hx_pkg
// Constants and controller/datapath interface types of the header extractor.
// ----------------------------------------------------------------------------
`default_nettype none

package l4hx_pkg;

  // Frame layout.
  localparam int MAC_HEADER_BYTES = 14;
  localparam int IP_OFS_PROTO     = 9;
  localparam int IP_OFS_SRC       = 12;
  localparam int IP_OFS_DST       = 16;
  localparam int IP_MIN_BYTES     = 20;
  localparam int L4_MIN_BYTES     = 20;
  localparam int PAYLOAD_SKIP     = 8;
  localparam int SNIPPET_BYTES_DEF = 50;

  localparam int POS_W      = 16;
  localparam int SNIP_IDX_W = 6;

  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] PROTO_UDP = 8'd17;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;       // frame byte transfer
    logic frame_end;  // the transfer carries the final byte
    logic rd_issue;   // read the snippet store at the emit index
    logic snip_load;  // load the snippet result into the output register
  } l4hx_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;   // output register can take a result this cycle
    logic snip_none;  // the frame ending now emits no snippet bytes
    logic snip_last;  // the current emit index is the final snippet byte
  } l4hx_sts_t;

endpackage

`default_nettype wire

>>> hdl/ipv4_l4_header_extractor_unit.sv
// ----------------------------------------------------------------------------
// ipv4_l4_header_extractor_unit
// Parses IPv4 and TCP/UDP header fields from a byte stream of Ethernet frames.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake         Contents
//  in_      input      in_valid/stall    one frame byte, last flag, wire length
//  out_     output     out_valid/stall   frame summary, then snippet bytes
//
//  Frame bytes are taken one per cycle while the output register is free
//  and no snippet is being emitted. After the final byte the summary is
//  loaded at once; each snippet byte then passes through a snippet RAM
//  read and an output load, with the input stalled until the final load.
//  Reset clears the frame capture and the controller; the snippet RAM needs
//  no clearing since only entries written in the current frame are read.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4_l4_header_extractor_unit #(
  parameter int SNIPPET_BYTES = l4hx_pkg::SNIPPET_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_last_byte,
  input  wire logic [15:0] in_wire_length,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_is_summary,
  output logic             out_accepted,
  output logic             out_transport_kind,
  output logic [31:0]      out_source_address,
  output logic [31:0]      out_dest_address,
  output logic [15:0]      out_source_port,
  output logic [15:0]      out_dest_port,
  output logic [15:0]      out_frame_length,
  output logic [7:0]       out_snippet_byte,
  output logic [5:0]       out_snippet_index,
  output logic             out_last_result
);

  l4hx_pkg::l4hx_cmd_t cmd;
  l4hx_pkg::l4hx_sts_t sts;

  l4hx_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_last_byte (in_last_byte),
    .in_stall     (in_stall),
    .sts          (sts),
    .cmd          (cmd)
  );

  l4hx_dpath #(
    .SNIPPET_BYTES (SNIPPET_BYTES)
  ) u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_data_byte       (in_data_byte),
    .in_wire_length     (in_wire_length),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_is_summary     (out_is_summary),
    .out_accepted       (out_accepted),
    .out_transport_kind (out_transport_kind),
    .out_source_address (out_source_address),
    .out_dest_address   (out_dest_address),
    .out_source_port    (out_source_port),
    .out_dest_port      (out_dest_port),
    .out_frame_length   (out_frame_length),
    .out_snippet_byte   (out_snippet_byte),
    .out_snippet_index  (out_snippet_index),
    .out_last_result    (out_last_result)
  );

endmodule

`default_nettype wire

>>> hdl/l4hx_ram.sv
// ----------------------------------------------------------------------------
// l4hx_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module l4hx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 50,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]  wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> hdl/l4hx_dpath.sv
// ----------------------------------------------------------------------------
// l4hx_dpath
// Header field capture, snippet store, acceptance checks and result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "ipv4_l4_header_extractor_unit_defines.svh"

module l4hx_dpath #(
  parameter int SNIPPET_BYTES = l4hx_pkg::SNIPPET_BYTES_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire l4hx_pkg::l4hx_cmd_t   cmd,
  output l4hx_pkg::l4hx_sts_t        sts,
  input  wire logic [7:0]            in_data_byte,
  input  wire logic [15:0]           in_wire_length,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic                       out_is_summary,
  output logic                       out_accepted,
  output logic                       out_transport_kind,
  output logic [31:0]                out_source_address,
  output logic [31:0]                out_dest_address,
  output logic [15:0]                out_source_port,
  output logic [15:0]                out_dest_port,
  output logic [15:0]                out_frame_length,
  output logic [7:0]                 out_snippet_byte,
  output logic [5:0]                 out_snippet_index,
  output logic                       out_last_result
);

  localparam int POS_W  = l4hx_pkg::POS_W;
  localparam int FILL_W = $clog2(SNIPPET_BYTES + 1);
  localparam int ADDR_W = (SNIPPET_BYTES > 1) ? $clog2(SNIPPET_BYTES) : 1;

  localparam logic [POS_W-1:0] IP_OFS  = POS_W'(l4hx_pkg::MAC_HEADER_BYTES);
  localparam logic [POS_W-1:0] POS_MAX = '1;
  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(SNIPPET_BYTES);

  // Frame capture registers.
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [3:0]        hw_r, hw_nxt;
  logic [7:0]        proto_r, proto_nxt;
  logic [31:0]       src_r, src_nxt;
  logic [31:0]       dst_r, dst_nxt;
  logic [15:0]       sport_r, sport_nxt;
  logic [15:0]       dport_r, dport_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;

  // Snippet emission counters.
  logic [FILL_W-1:0] cnt_r, cnt_nxt;
  logic [FILL_W-1:0] k_r, k_nxt;

  // Output register.
  logic        out_valid_r, out_valid_nxt;
  logic        is_sum_r, acc_r, kind_r, last_r;
  logic [31:0] osrc_r, odst_r;
  logic [15:0] osport_r, odport_r, olen_r;
  logic [7:0]  obyte_r;
  logic [5:0]  oidx_r;

  // Per-byte decode.
  logic [3:0]       ihl;
  logic [POS_W-1:0] t_ofs, s_ofs, s_end, caplen;
  logic             snip_wr;
  logic [FILL_W-1:0] fill_new;
  logic [7:0]       proto_new;
  logic [31:0]      src_new, dst_new;
  logic [15:0]      sport_new, dport_new;
  logic             frame_ok;
  logic [FILL_W-1:0] cnt_new;
  logic [7:0]       ram_rdata;

  always_comb begin
    ihl   = (pos_r == IP_OFS) ? in_data_byte[3:0] : hw_r;
    t_ofs = IP_OFS + {{(POS_W-6){1'b0}}, ihl, 2'b00};
    s_ofs = t_ofs + POS_W'(l4hx_pkg::PAYLOAD_SKIP);
    s_end = s_ofs + POS_W'(SNIPPET_BYTES);

    snip_wr  = cmd.take && (pos_r >= s_ofs) && (pos_r < s_end) && (fill_r < FILL_MAX);
    fill_new = fill_r + FILL_W'(snip_wr);

    proto_new = proto_r;
    if (cmd.take && pos_r == IP_OFS + POS_W'(l4hx_pkg::IP_OFS_PROTO)) begin
      proto_new = in_data_byte;
    end

    src_new = src_r;
    dst_new = dst_r;
    for (int i = 0; i < 4; i++) begin
      if (cmd.take && pos_r == IP_OFS + POS_W'(l4hx_pkg::IP_OFS_SRC + i)) begin
        src_new[31-8*i -: 8] = in_data_byte;
      end
      if (cmd.take && pos_r == IP_OFS + POS_W'(l4hx_pkg::IP_OFS_DST + i)) begin
        dst_new[31-8*i -: 8] = in_data_byte;
      end
    end

    sport_new = sport_r;
    dport_new = dport_r;
    if (cmd.take && pos_r == t_ofs) begin
      sport_new[15:8] = in_data_byte;
    end
    if (cmd.take && pos_r == t_ofs + POS_W'(1)) begin
      sport_new[7:0] = in_data_byte;
    end
    if (cmd.take && pos_r == t_ofs + POS_W'(2)) begin
      dport_new[15:8] = in_data_byte;
    end
    if (cmd.take && pos_r == t_ofs + POS_W'(3)) begin
      dport_new[7:0] = in_data_byte;
    end

    caplen   = (pos_r != POS_MAX) ? pos_r + POS_W'(1) : POS_MAX;
    frame_ok = ((proto_new == l4hx_pkg::PROTO_TCP) || (proto_new == l4hx_pkg::PROTO_UDP))
            && (caplen >= IP_OFS + POS_W'(l4hx_pkg::IP_MIN_BYTES))
            && (caplen >= t_ofs)
            && (caplen >= t_ofs + POS_W'(l4hx_pkg::L4_MIN_BYTES));
    cnt_new  = frame_ok ? fill_new : '0;
  end

  // Frame state: updated on each byte transfer, cleared after the final one.
  always_comb begin
    pos_nxt   = pos_r;
    hw_nxt    = hw_r;
    proto_nxt = proto_r;
    src_nxt   = src_r;
    dst_nxt   = dst_r;
    sport_nxt = sport_r;
    dport_nxt = dport_r;
    fill_nxt  = fill_r;
    cnt_nxt   = cnt_r;
    k_nxt     = k_r;
    if (cmd.frame_end) begin
      pos_nxt   = '0;
      hw_nxt    = '0;
      proto_nxt = '0;
      src_nxt   = '0;
      dst_nxt   = '0;
      sport_nxt = '0;
      dport_nxt = '0;
      fill_nxt  = '0;
      cnt_nxt   = cnt_new;
      k_nxt     = '0;
    end else if (cmd.take) begin
      pos_nxt   = (pos_r != POS_MAX) ? pos_r + POS_W'(1) : POS_MAX;
      hw_nxt    = ihl;
      proto_nxt = proto_new;
      src_nxt   = src_new;
      dst_nxt   = dst_new;
      sport_nxt = sport_new;
      dport_nxt = dport_new;
      fill_nxt  = fill_new;
    end else if (cmd.snip_load) begin
      k_nxt = k_r + FILL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      hw_r    <= '0;
      proto_r <= '0;
      src_r   <= '0;
      dst_r   <= '0;
      sport_r <= '0;
      dport_r <= '0;
      fill_r  <= '0;
      cnt_r   <= '0;
      k_r     <= '0;
    end else begin
      pos_r   <= pos_nxt;
      hw_r    <= hw_nxt;
      proto_r <= proto_nxt;
      src_r   <= src_nxt;
      dst_r   <= dst_nxt;
      sport_r <= sport_nxt;
      dport_r <= dport_nxt;
      fill_r  <= fill_nxt;
      cnt_r   <= cnt_nxt;
      k_r     <= k_nxt;
    end
  end

  l4hx_ram #(
    .WIDTH (8),
    .DEPTH (SNIPPET_BYTES)
  ) u_snip_ram (
    .clk     (clk),
    .wr_en   (snip_wr),
    .wr_addr (fill_r[ADDR_W-1:0]),
    .wr_data (in_data_byte),
    .rd_en   (cmd.rd_issue),
    .rd_addr (k_r[ADDR_W-1:0]),
    .rd_data (ram_rdata)
  );

  // Output register: a new result is loaded only when the old one is gone.
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (cmd.frame_end || cmd.snip_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.frame_end) begin
      is_sum_r <= 1'b1;
      acc_r    <= frame_ok;
      kind_r   <= (proto_new == l4hx_pkg::PROTO_UDP);
      osrc_r   <= src_new;
      odst_r   <= dst_new;
      osport_r <= sport_new;
      odport_r <= dport_new;
      olen_r   <= in_wire_length;
      obyte_r  <= '0;
      oidx_r   <= '0;
      last_r   <= (cnt_new == '0);
    end else if (cmd.snip_load) begin
      is_sum_r <= 1'b0;
      acc_r    <= 1'b1;
      kind_r   <= 1'b0;
      osrc_r   <= '0;
      odst_r   <= '0;
      osport_r <= '0;
      odport_r <= '0;
      olen_r   <= '0;
      obyte_r  <= ram_rdata;
      oidx_r   <= l4hx_pkg::SNIP_IDX_W'(k_r);
      last_r   <= sts.snip_last;
    end
  end

  assign sts.out_free  = !out_valid_r || !out_stall;
  assign sts.snip_none = (cnt_new == '0);
  assign sts.snip_last = (({1'b0, k_r} + (FILL_W+1)'(1)) == {1'b0, cnt_r});

  assign out_valid          = out_valid_r;
  assign out_is_summary     = is_sum_r;
  assign out_accepted       = acc_r;
  assign out_transport_kind = kind_r;
  assign out_source_address = osrc_r;
  assign out_dest_address   = odst_r;
  assign out_source_port    = osport_r;
  assign out_dest_port      = odport_r;
  assign out_frame_length   = olen_r;
  assign out_snippet_byte   = obyte_r;
  assign out_snippet_index  = oidx_r;
  assign out_last_result    = last_r;

  `L4HX_ASSERT_SAME(a_fill_bound, 1'b1, fill_r <= FILL_MAX, "snippet fill beyond store depth")
  `L4HX_ASSERT_SAME(a_emit_in_range, cmd.snip_load, k_r < cnt_r, "snippet emit past count")
  `L4HX_ASSERT_NEXT(a_summary_loaded, cmd.frame_end, out_valid_r && is_sum_r, "summary not loaded")

endmodule

`default_nettype wire

>>> hdl/l4hx_ctrl.sv
// ----------------------------------------------------------------------------
// l4hx_ctrl
// Sequencer: byte intake, then snippet read and emit after a frame with snippet bytes.
// ----------------------------------------------------------------------------
`default_nettype none
`include "ipv4_l4_header_extractor_unit_defines.svh"

module l4hx_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  input  wire logic                 in_last_byte,
  output logic                      in_stall,
  input  wire l4hx_pkg::l4hx_sts_t  sts,
  output l4hx_pkg::l4hx_cmd_t       cmd
);

  localparam logic [1:0] S_RECV = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_LOAD = 2'd2;

  logic [1:0] state_r, state_nxt;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    in_stall      = 1'b1;
    unique case (state_r)
      S_RECV: begin
        in_stall      = !sts.out_free;
        cmd.take      = in_valid && sts.out_free;
        cmd.frame_end = cmd.take && in_last_byte;
        if (cmd.frame_end && !sts.snip_none) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        cmd.rd_issue = 1'b1;
        state_nxt    = S_LOAD;
      end
      S_LOAD: begin
        if (sts.out_free) begin
          cmd.snip_load = 1'b1;
          state_nxt     = sts.snip_last ? S_RECV : S_READ;
        end
      end
      default: begin
        state_nxt = S_RECV;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_RECV;
    end else begin
      state_r <= state_nxt;
    end
  end

  `L4HX_ASSERT_SAME(a_stall_busy, state_r != S_RECV, in_stall, "byte taken while emitting")
  `L4HX_ASSERT_NEXT(a_read_then_load, cmd.rd_issue, state_r == S_LOAD, "read not followed by load")
  `L4HX_ASSERT_NEXT(a_emit_done, cmd.snip_load && sts.snip_last, state_r == S_RECV, "emit not closed")

endmodule

`default_nettype wire
